[rtl/core/pfsa_pkg.sv]
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared types and constants for the page-frame stack allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

	localparam int STACK_DEPTH_DEF      = 4096;
	localparam int ENTRIES_PER_PAGE_DEF = 1024;

	localparam int PAGE_W   = 20;
	localparam int STATUS_W = 3;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	// Last usable page frame number
	localparam logic [PAGE_W:0] TOP_PAGE = 21'h0FFFFF;

	// Register index, taken from paddr[2]
	localparam logic REG_PAGING_ACTIVE = 1'b0;
	localparam logic REG_BUMP_START    = 1'b1;

	// Request function
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 3'd0,
		ST_PUSHED    = 3'd1,
		ST_STORAGE   = 3'd2,
		ST_IGNORED   = 3'd3,
		ST_OOM       = 3'd4,
		ST_DROPPED   = 3'd5
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic    bump_adv;
		logic    pop_rd;
		logic    push_wr;
		logic    grow;
		logic    res_load;
		logic    res_from_ram;
		logic    res_from_bump;
		status_t res_status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic bump_top;
		logic page_below;
		logic storage_full;
		logic can_grow;
		logic stack_full;
	} sts_t;

endpackage

[rtl/core/page_frame_stack_allocator_core.sv]
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_core
// Page-frame allocator: bump pointer while paging is off, free stack after.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive func and page_number and raise start; the
//   transaction is taken at a rising edge with start high and busy low.
//   func = allocate returns a page in result_page; func = free takes
//   page_number onto the free stack, grows storage, or ignores or drops it.
//   Result channel: done is high for exactly one cycle with result_page and
//   status. The receiver cannot stall, so it must capture the result then.
//   Result timing: done and the result are registered; a stack pop first
//   reads the free-stack RAM, whose read data is registered.
//   Throughput: one transaction per cycle while busy is low; busy is high
//   only during the RAM read of a pop, and no new request is taken then.
//   Configuration: APB registers paging_active (0x0) and bump_start_page
//   (0x4); write them only while the core is idle.
//   Reset clears the stack count, storage limit, bump pointer and registers.
//   The free-stack RAM is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_core #(
	parameter int STACK_DEPTH      = pfsa_pkg::STACK_DEPTH_DEF,
	parameter int ENTRIES_PER_PAGE = pfsa_pkg::ENTRIES_PER_PAGE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfsa_pkg::APB_AW-1:0]   paddr,
	input  logic [pfsa_pkg::APB_DW-1:0]   pwdata,
	output logic [pfsa_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [pfsa_pkg::PAGE_W-1:0]   page_number,
	// result channel
	output logic                          done,
	output logic [pfsa_pkg::PAGE_W-1:0]   result_page,
	output logic [pfsa_pkg::STATUS_W-1:0] status
);

	logic                        paging_active_q;
	logic [pfsa_pkg::PAGE_W-1:0] bump_start_page_q;
	logic                        cfg_wr;
	pfsa_pkg::cmd_t              cmd;
	pfsa_pkg::sts_t              sts;

	// Configuration registers: zero wait states, write in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_active_q   <= 1'b0;
			bump_start_page_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				pfsa_pkg::REG_PAGING_ACTIVE: paging_active_q   <= pwdata[0];
				pfsa_pkg::REG_BUMP_START:    bump_start_page_q <= pwdata[pfsa_pkg::PAGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pfsa_pkg::REG_PAGING_ACTIVE: prdata = {{(pfsa_pkg::APB_DW-1){1'b0}}, paging_active_q};
			pfsa_pkg::REG_BUMP_START:
				prdata = {{(pfsa_pkg::APB_DW-pfsa_pkg::PAGE_W){1'b0}}, bump_start_page_q};
			default: prdata = '0;
		endcase
	end

	// Sequencer: decide each transaction from the datapath status flags
	pfsa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.func          (func),
		.paging_active (paging_active_q),
		.sts           (sts),
		.cmd           (cmd),
		.busy          (busy)
	);

	// Datapath: counters, bump pointer, stack RAM, result registers
	pfsa_dpath #(
		.STACK_DEPTH      (STACK_DEPTH),
		.ENTRIES_PER_PAGE (ENTRIES_PER_PAGE)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.bump_start_page (bump_start_page_q),
		.page_number     (page_number),
		.cmd             (cmd),
		.sts             (sts),
		.done            (done),
		.result_page     (result_page),
		.status          (status)
	);

	// Every accepted transaction yields a result next cycle or after the pop
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction produced no result");

	// A pop in flight always completes on the following cycle
	a_pop_completes: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy && status == pfsa_pkg::ST_ALLOCATED))
		else $error("stack pop did not complete");

	// A result never overlaps a pending pop
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Non-allocation results carry a zero page
	a_zero_page: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != pfsa_pkg::ST_ALLOCATED) |-> (result_page == '0))
		else $error("nonzero page on non-allocation result");

endmodule

[rtl/core/pfsa_ram.sv]
// ----------------------------------------------------------------------------
// pfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfsa_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/pfsa_ctrl.sv]
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Request sequencer: decodes each transaction into datapath commands.
// ----------------------------------------------------------------------------
module pfsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             func,
	input  logic             paging_active,
	input  pfsa_pkg::sts_t   sts,
	output pfsa_pkg::cmd_t   cmd,
	output logic             busy
);

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q == S_POP);

	always_comb begin
		cmd            = '0;
		cmd.res_status = pfsa_pkg::ST_ALLOCATED;
		state_d        = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.res_load = 1'b1;
					if (func == pfsa_pkg::FUNC_ALLOC) begin
						if (paging_active) begin
							if (sts.empty) begin
								cmd.res_status = pfsa_pkg::ST_OOM;
							end else begin
								// result is loaded in S_POP, from the RAM
								cmd.res_load = 1'b0;
								cmd.pop_rd   = 1'b1;
								state_d      = S_POP;
							end
						end else if (sts.bump_top) begin
							cmd.res_status = pfsa_pkg::ST_OOM;
						end else begin
							cmd.bump_adv      = 1'b1;
							cmd.res_from_bump = 1'b1;
						end
					end else begin
						if (sts.page_below) begin
							cmd.res_status = pfsa_pkg::ST_IGNORED;
						end else if (sts.storage_full) begin
							if (sts.can_grow) begin
								cmd.grow       = 1'b1;
								cmd.res_status = pfsa_pkg::ST_STORAGE;
							end else begin
								cmd.res_status = pfsa_pkg::ST_DROPPED;
							end
						end else if (sts.stack_full) begin
							cmd.res_status = pfsa_pkg::ST_DROPPED;
						end else begin
							cmd.push_wr    = 1'b1;
							cmd.res_status = pfsa_pkg::ST_PUSHED;
						end
					end
				end
			end
			S_POP: begin
				cmd.res_load     = 1'b1;
				cmd.res_from_ram = 1'b1;
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/pfsa_dpath.sv]
// ----------------------------------------------------------------------------
// pfsa_dpath
// Counters, bump pointer, free-stack RAM and result registers.
// ----------------------------------------------------------------------------
module pfsa_dpath #(
	parameter int STACK_DEPTH      = pfsa_pkg::STACK_DEPTH_DEF,
	parameter int ENTRIES_PER_PAGE = pfsa_pkg::ENTRIES_PER_PAGE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pfsa_pkg::PAGE_W-1:0]   bump_start_page,
	input  logic [pfsa_pkg::PAGE_W-1:0]   page_number,
	input  pfsa_pkg::cmd_t                cmd,
	output pfsa_pkg::sts_t                sts,
	output logic                          done,
	output logic [pfsa_pkg::PAGE_W-1:0]   result_page,
	output logic [pfsa_pkg::STATUS_W-1:0] status
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int SUM_W  = $clog2(STACK_DEPTH + ENTRIES_PER_PAGE + 1);
	localparam logic [SUM_W-1:0] EPP_V   = SUM_W'(ENTRIES_PER_PAGE);
	localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] EPP_C   = CNT_W'(ENTRIES_PER_PAGE);

	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            limit_q;
	logic [pfsa_pkg::PAGE_W-1:0] bump_used_q;
	logic [pfsa_pkg::PAGE_W:0]   loc;
	logic [CNT_W-1:0]            count_dec;
	logic [pfsa_pkg::PAGE_W-1:0] rd_data;
	logic [pfsa_pkg::PAGE_W-1:0] res_page_d;

	logic                          done_q;
	logic [pfsa_pkg::PAGE_W-1:0]   result_page_q;
	pfsa_pkg::status_t             status_q;

	assign loc       = {1'b0, bump_start_page} + {1'b0, bump_used_q};
	assign count_dec = count_q - 1'b1;

	assign sts.empty        = (count_q == '0);
	assign sts.bump_top     = (loc >= pfsa_pkg::TOP_PAGE);
	assign sts.page_below   = ({1'b0, page_number} < loc);
	assign sts.storage_full = (limit_q <= count_q);
	assign sts.can_grow     = ((SUM_W'(limit_q) + EPP_V) <= DEPTH_V);
	assign sts.stack_full   = (count_q >= DEPTH_C);

	pfsa_ram #(
		.WIDTH (pfsa_pkg::PAGE_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.we      (cmd.push_wr),
		.waddr   (count_q[ADDR_W-1:0]),
		.wdata   (page_number),
		.re      (cmd.pop_rd),
		.raddr   (count_dec[ADDR_W-1:0]),
		.rdata_q (rd_data)
	);

	always_comb begin
		res_page_d = '0;
		if (cmd.res_from_ram) begin
			res_page_d = rd_data;
		end else if (cmd.res_from_bump) begin
			res_page_d = loc[pfsa_pkg::PAGE_W-1:0] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			limit_q     <= '0;
			bump_used_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
			if (cmd.push_wr) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop_rd) begin
				count_q <= count_dec;
			end
			if (cmd.grow) begin
				limit_q <= limit_q + EPP_C;
			end
			if (cmd.bump_adv) begin
				bump_used_q <= bump_used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			result_page_q <= res_page_d;
			status_q      <= cmd.res_status;
		end
	end

	assign done        = done_q;
	assign result_page = result_page_q;
	assign status      = status_q;

endmodule

[tb/sv/page_frame_stack_allocator_checker.sv]
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_checker
// Watches the request, result and configuration channels of the allocator,
// keeps its own copy of the allocator state, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_checker #(
	parameter int STACK_DEPTH      = pfsa_pkg::STACK_DEPTH_DEF,
	parameter int ENTRIES_PER_PAGE = pfsa_pkg::ENTRIES_PER_PAGE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pfsa_pkg::APB_AW-1:0]   paddr,
	input  logic [pfsa_pkg::APB_DW-1:0]   pwdata,
	input  logic [pfsa_pkg::APB_DW-1:0]   prdata,
	input  logic                          pready,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          func,
	input  logic [pfsa_pkg::PAGE_W-1:0]   page_number,
	input  logic                          done,
	input  logic [pfsa_pkg::PAGE_W-1:0]   result_page,
	input  logic [pfsa_pkg::STATUS_W-1:0] status,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [pfsa_pkg::PAGE_W-1:0] page;
		pfsa_pkg::status_t           st;
	} alloc_outcome_t;

	alloc_outcome_t    outcome_q[$];

	// shadow allocator state
	logic [pfsa_pkg::PAGE_W-1:0] frame_stack [STACK_DEPTH];
	int unsigned                 frames_held;
	int unsigned                 storage_entries;
	logic [pfsa_pkg::PAGE_W-1:0] bump_taken;
	logic                        paging_on;
	logic [pfsa_pkg::PAGE_W-1:0] bump_base;

	// Advance the shadow state by one request and return what it yields.
	function automatic alloc_outcome_t serve_request(input logic fn,
		input logic [pfsa_pkg::PAGE_W-1:0] pg);
		alloc_outcome_t o;
		logic [pfsa_pkg::PAGE_W:0] loc;
		o.page = '0;
		loc = {1'b0, bump_base} + {1'b0, bump_taken};
		if (fn == pfsa_pkg::FUNC_ALLOC) begin
			if (paging_on) begin
				if (frames_held == 0 || frames_held > STACK_DEPTH) begin
					o.st = pfsa_pkg::ST_OOM;
				end else begin
					frames_held = frames_held - 1;
					o.page = frame_stack[frames_held];
					o.st = pfsa_pkg::ST_ALLOCATED;
				end
			end else if (loc >= pfsa_pkg::TOP_PAGE) begin
				o.st = pfsa_pkg::ST_OOM;
			end else begin
				bump_taken = bump_taken + 1'b1;
				o.page = loc[pfsa_pkg::PAGE_W-1:0] + 1'b1;
				o.st = pfsa_pkg::ST_ALLOCATED;
			end
		end else if ({1'b0, pg} < loc) begin
			o.st = pfsa_pkg::ST_IGNORED;
		end else if (storage_entries <= frames_held) begin
			if (storage_entries + ENTRIES_PER_PAGE <= STACK_DEPTH) begin
				storage_entries = storage_entries + ENTRIES_PER_PAGE;
				o.st = pfsa_pkg::ST_STORAGE;
			end else begin
				o.st = pfsa_pkg::ST_DROPPED;
			end
		end else if (frames_held < STACK_DEPTH) begin
			frame_stack[frames_held] = pg;
			frames_held = frames_held + 1;
			o.st = pfsa_pkg::ST_PUSHED;
		end else begin
			o.st = pfsa_pkg::ST_DROPPED;
		end
		return o;
	endfunction

	always @(posedge clk) begin
		alloc_outcome_t want;
		logic [pfsa_pkg::APB_DW-1:0] reg_value;
		int fails;
		fails = 0;
		if (!arst_n) begin
			outcome_q.delete();
			frames_held     = 0;
			storage_entries = 0;
			bump_taken      = '0;
			paging_on       = 1'b0;
			bump_base       = '0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// configuration transactions
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[2])
						pfsa_pkg::REG_PAGING_ACTIVE: paging_on = pwdata[0];
						pfsa_pkg::REG_BUMP_START:
							bump_base = pwdata[pfsa_pkg::PAGE_W-1:0];
						default: ;
					endcase
				end else begin
					reg_value = (paddr[2] == pfsa_pkg::REG_PAGING_ACTIVE) ?
						{{(pfsa_pkg::APB_DW-1){1'b0}}, paging_on} :
						{{(pfsa_pkg::APB_DW-pfsa_pkg::PAGE_W){1'b0}}, bump_base};
					if (prdata !== reg_value) begin
						$display("%0t: register %0d read: expected %h, actual %h",
							$time, paddr[2], reg_value, prdata);
						fails++;
					end
				end
			end
			// results
			if (done) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result with nothing outstanding: expected none, actual %h/%0d",
						$time, result_page, status);
					fails++;
				end else begin
					want = outcome_q.pop_front();
					if (result_page !== want.page) begin
						$display("%0t: result_page: expected %h, actual %h",
							$time, want.page, result_page);
						fails++;
					end
					if (status !== want.st) begin
						$display("%0t: status: expected %0d, actual %0d",
							$time, want.st, status);
						fails++;
					end
				end
			end
			// requests
			if (start && !busy)
				outcome_q.push_back(serve_request(func, page_number));
			pending <= outcome_q.size();
			errors  <= errors + fails;
		end
	end

endmodule

[tb/sv/page_frame_stack_allocator_core_test.sv]
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_core_test
// Drives allocate and free requests and register writes into the allocator
// core and gives the verdict; a side checker predicts and compares results.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = pfsa_pkg::STACK_DEPTH_DEF;
	localparam int PAGE_SLOTS  = pfsa_pkg::ENTRIES_PER_PAGE_DEF;
	localparam int PAGE_BITS   = pfsa_pkg::PAGE_W;
	localparam int STALL_LIMIT = 400;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [pfsa_pkg::APB_AW-1:0]   paddr;
	logic [pfsa_pkg::APB_DW-1:0]   pwdata;
	logic [pfsa_pkg::APB_DW-1:0]   prdata;
	logic                          pready;
	logic                          start;
	logic                          busy;
	logic                          func;
	logic [PAGE_BITS-1:0]          page_number;
	logic                          done;
	logic [PAGE_BITS-1:0]          result_page;
	logic [pfsa_pkg::STATUS_W-1:0] status;

	int errors;
	int pending;
	int stall_cycles;

	// stimulus-side view of the configuration, used to aim frees
	logic                 gaps_on;
	logic                 paging_cfg;
	logic [PAGE_BITS-1:0] base_cfg;

	page_frame_stack_allocator_core #(
		.STACK_DEPTH      (DEPTH),
		.ENTRIES_PER_PAGE (PAGE_SLOTS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.page_number (page_number),
		.done        (done),
		.result_page (result_page),
		.status      (status)
	);

	page_frame_stack_allocator_checker #(
		.STACK_DEPTH      (DEPTH),
		.ENTRIES_PER_PAGE (PAGE_SLOTS)
	) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.page_number (page_number),
		.done        (done),
		.result_page (result_page),
		.status      (status),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: count cycles in which no transaction of any kind completes.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Present one request and hold it until the edge that takes it.
	// Called right after a rising edge; returns right after the accepting edge,
	// so a following call keeps start high without a second assignment.
	task automatic issue(input logic fn, input logic [PAGE_BITS-1:0] pg);
		start       <= 1'b1;
		func        <= fn;
		page_number <= pg;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start for a random burst now and then, when gaps are enabled.
	task automatic pause_sender();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every outstanding result is back.
	// The first edge lets the checker count the last accepted request;
	// the tail covers the pop path, whose result waits on the RAM read.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One register transaction: setup cycle, access cycle until pready,
	// then psel and penable drop before it returns, so back-to-back calls never collide.
	task automatic reg_access(input logic wr, input logic idx,
		input logic [pfsa_pkg::APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write both registers with random junk in the unused upper bits.
	task automatic configure(input logic pg_on, input logic [PAGE_BITS-1:0] base);
		logic [pfsa_pkg::APB_DW-1:0] junk;
		junk = $urandom;
		paging_cfg = pg_on;
		base_cfg   = base;
		reg_access(1'b1, pfsa_pkg::REG_PAGING_ACTIVE, {junk[pfsa_pkg::APB_DW-1:1], pg_on});
		junk = $urandom;
		reg_access(1'b1, pfsa_pkg::REG_BUMP_START, {junk[pfsa_pkg::APB_DW-1:PAGE_BITS], base});
		if ($urandom_range(0, 1) == 0) begin
			reg_access(1'b0, pfsa_pkg::REG_PAGING_ACTIVE, $urandom);
			reg_access(1'b0, pfsa_pkg::REG_BUMP_START, $urandom);
		end
	endtask

	// Aim most frees well above the bump location so they reach the stack;
	// the rest take any page and may land below it.
	function automatic logic [PAGE_BITS-1:0] pick_free_page(input logic [PAGE_BITS-1:0] base);
		logic [PAGE_BITS:0] floor_pg;
		floor_pg = {1'b0, base} + 21'h1000;
		if (floor_pg > 21'h0FFFFF)
			floor_pg = 21'h0FFFFF;
		if ($urandom_range(0, 3) == 0)
			return PAGE_BITS'($urandom);
		return PAGE_BITS'($urandom_range(floor_pg, 20'hFFFFF));
	endfunction

	initial begin
		int seg;
		int n;
		int pick;
		logic fn;
		logic [PAGE_BITS-1:0] base;

		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		start       = 1'b0;
		func        = pfsa_pkg::FUNC_ALLOC;
		page_number = '0;
		gaps_on     = 1'b0;
		paging_cfg  = 1'b0;
		base_cfg    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, bump allocation from page zero.
		reg_access(1'b0, pfsa_pkg::REG_PAGING_ACTIVE, '0);
		reg_access(1'b0, pfsa_pkg::REG_BUMP_START, '0);
		issue(pfsa_pkg::FUNC_ALLOC, 20'hFFFFF);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h00000);
		// free below the bump location is ignored
		issue(pfsa_pkg::FUNC_FREE, 20'h00000);
		// first free at the bump location becomes storage, the rest push
		issue(pfsa_pkg::FUNC_FREE, 20'h00002);
		issue(pfsa_pkg::FUNC_FREE, 20'hFFFFF);
		issue(pfsa_pkg::FUNC_FREE, 20'h5A5A5);
		issue(pfsa_pkg::FUNC_FREE, 20'hA5A5A);
		settle();

		// Directed: stack pops in reverse order, then the empty stack.
		configure(1'b1, 20'h00000);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h00000);
		issue(pfsa_pkg::FUNC_ALLOC, 20'hFFFFF);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h12345);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h00000);
		issue(pfsa_pkg::FUNC_FREE, 20'h12345);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h00000);
		settle();

		// Directed: bump up to the top page, then out of memory.
		configure(1'b0, 20'hFFFFC);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h00000);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h00000);
		issue(pfsa_pkg::FUNC_FREE, 20'hFFFFF);
		issue(pfsa_pkg::FUNC_FREE, 20'hFFFFE);
		settle();
		configure(1'b0, 20'hFFFFF);
		issue(pfsa_pkg::FUNC_ALLOC, 20'h00000);
		issue(pfsa_pkg::FUNC_FREE, 20'h00000);
		settle();

		// Random segments, each under its own configuration.
		for (seg = 0; seg < 12; seg++) begin
			pick = $urandom_range(0, 7);
			case (pick)
				0, 1, 2: base = PAGE_BITS'($urandom_range(0, 1023));
				3:       base = 20'h00000;
				5:       base = 20'hFFF00 | PAGE_BITS'($urandom_range(0, 255));
				6:       base = 20'hFFFFF;
				default: base = PAGE_BITS'($urandom);
			endcase
			configure(seg < 2 ? seg[0] : 1'($urandom_range(0, 1)), base);
			// every fourth segment runs without gaps
			gaps_on = (seg % 4 != 3);
			for (n = 0; n < 32; n++) begin
				fn = ($urandom_range(0, 99) < (paging_cfg ? 50 : 40)) ?
					pfsa_pkg::FUNC_FREE : pfsa_pkg::FUNC_ALLOC;
				issue(fn, fn == pfsa_pkg::FUNC_FREE ? pick_free_page(base_cfg) :
					PAGE_BITS'($urandom));
				pause_sender();
			end
			settle();
		end

		// Final stretch back to back, no idling.
		gaps_on = 1'b0;
		configure(1'b1, 20'h00000);
		for (n = 0; n < 40; n++) begin
			fn = ($urandom_range(0, 99) < 60) ? pfsa_pkg::FUNC_FREE : pfsa_pkg::FUNC_ALLOC;
			issue(fn, fn == pfsa_pkg::FUNC_FREE ? pick_free_page(base_cfg) :
				PAGE_BITS'($urandom));
		end
		settle();

		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
